>>> design/dnapk_pkg.sv
// ----------------------------------------------------------------------------
// dnapk_pkg
// Shared types, register indexes and base-letter encodings for the read
// prefix key and suffix packing block.
// ----------------------------------------------------------------------------
`default_nettype none

package dnapk_pkg;

  // Field widths
  localparam int LETTER_W   = 5;
  localparam int PLEN_W     = 5;
  localparam int CLEN_W     = 16;
  localparam int VALUE_W    = 64;
  localparam int NCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Defaults and limits
  localparam int unsigned MAX_READ_LENGTH_DEF = 65535;
  localparam int          BASES_PER_WORD      = 16;
  localparam int          NIBBLE_W            = 4;
  localparam int          MAX_KEY_BASES       = 27;
  localparam int          PLEN_RESET          = 8;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LIMIT_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LENGTH   = 2'd2;

  // Letter codes (alphabet index)
  localparam logic [LETTER_W-1:0] LETTER_A = 5'd0;
  localparam logic [LETTER_W-1:0] LETTER_C = 5'd2;
  localparam logic [LETTER_W-1:0] LETTER_G = 5'd6;
  localparam logic [LETTER_W-1:0] LETTER_T = 5'd19;

  // Result kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  function automatic logic [2:0] key_digit(input logic [LETTER_W-1:0] letter);
    logic [2:0] d;
    case (letter)
      LETTER_A: d = 3'd0;
      LETTER_C: d = 3'd1;
      LETTER_G: d = 3'd2;
      LETTER_T: d = 3'd3;
      default:  d = 3'd4;
    endcase
    return d;
  endfunction

  function automatic logic [NIBBLE_W-1:0] one_hot_nibble(input logic [LETTER_W-1:0] letter);
    logic [NIBBLE_W-1:0] n;
    case (letter)
      LETTER_A: n = 4'b0001;
      LETTER_C: n = 4'b0010;
      LETTER_G: n = 4'b0100;
      LETTER_T: n = 4'b1000;
      default:  n = 4'b0000;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/dna_read_prefix_key_and_pack.sv
// ----------------------------------------------------------------------------
// dna_read_prefix_key_and_pack
// Folds the leading bases of a read into a base-5 key and packs the rest as
// one-hot nibbles, sixteen to a 64-bit word.
// ----------------------------------------------------------------------------
// Input channel: one base per transfer (letter_i, last_base_i), valid/ready.
// Output channel: one result per transfer (kind_o, value_o, last_of_read_o).
// A base produces zero, one or two results; they enter a four-entry output
// queue in the same cycle the base is taken and are shown from the next
// cycle on if no older result is still queued.
// Throughput is one base per cycle while in_ready_o is high, which holds
// while the queue has room for two results. With out_ready_i high, output
// drains one result per cycle and bases giving at most one result each
// never stall. When the receiver stalls, results collect in the queue and
// input stops once fewer than two slots are free; nothing is dropped.
// Reset clears the read state and the queue and loads prefix_length = 8,
// compare limit off, compare_length = 0. Register writes (cfg_we_i) take
// effect on the next base and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_read_prefix_key_and_pack
  import dnapk_pkg::*;
#(
  parameter int unsigned MAX_READ_LENGTH = MAX_READ_LENGTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // bases in
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [LETTER_W-1:0]   letter_i,
  input  wire logic                  last_base_i,
  // results out
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       kind_o,
  output logic [VALUE_W-1:0]         value_o,
  output logic                       last_of_read_o
);

  localparam int POS_W = $clog2(64'(MAX_READ_LENGTH) + 64'd1);
  localparam int CMP_W = ((POS_W > CLEN_W) ? POS_W : CLEN_W) + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_READ_LENGTH);

  // Configuration registers
  logic [PLEN_W-1:0] plen_q;
  logic              limit_q;
  logic [CLEN_W-1:0] clen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= PLEN_W'(PLEN_RESET);
      limit_q <= 1'b0;
      clen_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREFIX_LENGTH:    plen_q  <= cfg_data_i[PLEN_W-1:0];
        CFG_COMPARE_LIMIT_ON: limit_q <= cfg_data_i[0];
        CFG_COMPARE_LENGTH:   clen_q  <= cfg_data_i[CLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [VALUE_W-1:0] key_q, key_d;
  logic [VALUE_W-1:0] word_q, word_d;
  logic [NCNT_W-1:0]  ncnt_q, ncnt_d;
  logic               fin_q, fin_d;

  // Output queue
  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic in_fire, out_fire;
  assign in_ready_o  = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  // Per-base step
  logic [PLEN_W-1:0]   plen_eff;
  logic [CMP_W-1:0]    p_ext, p1_ext, plen_ext, clen_ext;
  logic [VALUE_W-1:0]  key_next, word_next;
  logic [NCNT_W-1:0]   ncnt_next;
  logic                key_emit, key_last;
  logic [VALUE_W-1:0]  key_val;
  logic                word_emit, word_end, fin_mid;
  result_t             e0, e1;
  logic [1:0]          n_push;

  always_comb begin
    plen_eff  = (plen_q > PLEN_W'(MAX_KEY_BASES)) ? PLEN_W'(MAX_KEY_BASES) : plen_q;
    p_ext     = CMP_W'(pos_q);
    p1_ext    = p_ext + CMP_W'(1);
    plen_ext  = CMP_W'(plen_eff);
    clen_ext  = CMP_W'(clen_q);
    key_next  = (key_q << 2) + key_q + VALUE_W'(key_digit(letter_i));
    word_next = {word_q[VALUE_W-NIBBLE_W-1:0], one_hot_nibble(letter_i)};
    ncnt_next = ncnt_q + NCNT_W'(1);

    key_emit  = 1'b0;
    key_last  = 1'b0;
    key_val   = key_next;
    word_emit = 1'b0;
    word_end  = 1'b0;
    fin_mid   = fin_q;
    key_d     = key_q;
    word_d    = word_q;
    ncnt_d    = ncnt_q;

    if (!fin_q) begin
      if (p_ext < plen_ext) begin
        key_d = key_next;
        if ((p1_ext == plen_ext) || last_base_i) begin
          key_emit = 1'b1;
          key_last = last_base_i || (limit_q && (clen_ext <= p1_ext));
          fin_mid  = key_last;
        end
      end else begin
        // zero-length prefix: empty key on the first base
        if ((plen_eff == '0) && (pos_q == '0)) begin
          key_emit = 1'b1;
          key_val  = '0;
          key_last = limit_q && (clen_q == '0);
          fin_mid  = key_last;
        end
        if (!fin_mid && !(limit_q && (p_ext >= clen_ext))) begin
          word_end = last_base_i || (limit_q && (p1_ext == clen_ext));
          if ((ncnt_q == NCNT_W'(BASES_PER_WORD - 1)) || word_end) begin
            word_emit = 1'b1;
            word_d    = '0;
            ncnt_d    = '0;
            fin_mid   = word_end;
          end else begin
            word_d = word_next;
            ncnt_d = ncnt_next;
          end
        end
      end
    end

    fin_d = fin_mid;
    pos_d = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
    if (last_base_i) begin
      pos_d  = '0;
      key_d  = '0;
      word_d = '0;
      ncnt_d = '0;
      fin_d  = 1'b0;
    end

    e1 = '{kind: KIND_WORD, value: word_next, last: word_end};
    e0 = key_emit ? '{kind: KIND_KEY, value: key_val, last: key_last} : e1;
    n_push = {1'b0, key_emit} + {1'b0, word_emit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      key_q  <= '0;
      word_q <= '0;
      ncnt_q <= '0;
      fin_q  <= 1'b0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      key_q  <= key_d;
      word_q <= word_d;
      ncnt_q <= ncnt_d;
      fin_q  <= fin_d;
    end
  end

  // Queue storage, up to two writes per transfer
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_push != 2'd0)) begin
      mem_q[wr_ptr_q] <= e0;
    end
    if (in_fire && (n_push == 2'd2)) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= e1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = cnt_d + QCNT_W'(n_push);
    end
    if (out_fire) begin
      cnt_d = cnt_d - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  result_t head;
  assign head           = mem_q[rd_ptr_q];
  assign kind_o         = head.kind;
  assign value_o        = head.value;
  assign last_of_read_o = head.last;

  // Assertions
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("output queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (QPTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

  a_nibble_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q < NCNT_W'(BASES_PER_WORD))
    else $error("partial word holds a full word of nibbles");

  a_read_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_base_i) |=> (pos_q == '0) && !fin_q && (ncnt_q == '0))
    else $error("read state not cleared after last base");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !fin_q && fin_d && !last_base_i) |-> (n_push != 2'd0))
    else $error("read finished without a marked result");

endmodule

`default_nettype wire

>>> dv/dnapk_result_checker.sv
// ----------------------------------------------------------------------------
// dnapk_result_checker
// Watches the register port and both channels of the read prefix key and
// suffix packing block. Each accepted base is run through a local model of
// the key folding and nibble packing, and each accepted result is compared
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module dnapk_result_checker
  import dnapk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [LETTER_W-1:0]   letter_i,
  input  logic                  last_base_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  kind_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic                  last_of_read_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o
);

  localparam int KEY_RADIX   = 5;
  localparam int OTHER_RANK  = 4;
  localparam int MAX_REPORTS = 40;

  // register copies
  logic [PLEN_W-1:0] plen_reg;
  logic              limit_on_reg;
  logic [CLEN_W-1:0] clen_reg;

  // per-read state
  int unsigned        read_pos;
  logic [VALUE_W-1:0] key_acc;
  logic [VALUE_W-1:0] word_acc;
  int unsigned        nibbles_held;
  bit                 read_closed;

  result_t expected_results[$];
  result_t want;
  int      fail_count = 0;

  assign fail_count_o = fail_count;

  // A, C, G, T rank 0..3; anything else ranks as other
  function automatic int base_rank(input logic [LETTER_W-1:0] letter);
    case (letter)
      LETTER_A: return 0;
      LETTER_C: return 1;
      LETTER_G: return 2;
      LETTER_T: return 3;
      default:  return OTHER_RANK;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want_v,
                                 input logic [VALUE_W-1:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  task automatic push_result(input logic kind, input logic [VALUE_W-1:0] value,
                             input bit fin);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = fin;
    expected_results.push_back(r);
  endtask

  task automatic clear_read();
    read_pos     = 0;
    key_acc      = '0;
    word_acc     = '0;
    nibbles_held = 0;
    read_closed  = 1'b0;
  endtask

  // Expected results of one accepted base.
  task automatic fold_base(input logic [LETTER_W-1:0] letter, input bit last);
    int unsigned eff_plen;
    int unsigned pos;
    int          rank;
    bit          fin;
    bit          suffix_end;
    eff_plen = (plen_reg > MAX_KEY_BASES) ? MAX_KEY_BASES : plen_reg;
    pos      = read_pos;
    rank     = base_rank(letter);
    if (!read_closed) begin
      if (pos < eff_plen) begin
        key_acc = key_acc * KEY_RADIX + rank;
        if (pos + 1 == eff_plen || last) begin
          fin = last || (limit_on_reg && clen_reg <= pos + 1);
          push_result(KIND_KEY, key_acc, fin);
          if (fin) read_closed = 1'b1;
        end
      end else begin
        // empty prefix: a zero key goes out for the first base, ahead of its word
        if (eff_plen == 0 && pos == 0) begin
          fin = limit_on_reg && clen_reg == 0;
          push_result(KIND_KEY, '0, fin);
          if (fin) read_closed = 1'b1;
        end
        if (!read_closed && !(limit_on_reg && pos >= clen_reg)) begin
          word_acc = {word_acc[VALUE_W-NIBBLE_W-1:0],
                      (rank == OTHER_RANK) ? 4'b0000 : NIBBLE_W'(1 << rank)};
          nibbles_held++;
          suffix_end = last || (limit_on_reg && pos + 1 == clen_reg);
          if (nibbles_held >= BASES_PER_WORD || suffix_end) begin
            push_result(KIND_WORD, word_acc, suffix_end);
            word_acc     = '0;
            nibbles_held = 0;
            if (suffix_end) read_closed = 1'b1;
          end
        end
      end
    end
    if (last) begin
      clear_read();
    end else if (read_pos < MAX_READ_LENGTH_DEF) begin
      read_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_reg     = PLEN_W'(PLEN_RESET);
      limit_on_reg = 1'b0;
      clen_reg     = '0;
      clear_read();
      expected_results.delete();
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PREFIX_LENGTH:    plen_reg = cfg_data_i[PLEN_W-1:0];
          CFG_COMPARE_LIMIT_ON: limit_on_reg = cfg_data_i[0];
          CFG_COMPARE_LENGTH:   clen_reg = cfg_data_i[CLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result value", '0, value_i);
        end else begin
          want = expected_results.pop_front();
          if (kind_i !== want.kind) begin
            report_mismatch("kind", VALUE_W'(want.kind), VALUE_W'(kind_i));
          end
          if (value_i !== want.value) report_mismatch("value", want.value, value_i);
          if (last_of_read_i !== want.last) begin
            report_mismatch("last_of_read", VALUE_W'(want.last), VALUE_W'(last_of_read_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) fold_base(letter_i, last_base_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> dv/dna_read_prefix_key_and_pack_test.sv
// ----------------------------------------------------------------------------
// dna_read_prefix_key_and_pack_test
// Drives reads into the prefix key and suffix packing block: a short directed
// set of corner reads, an output hold-off that backs up the input, then
// random reads under random register settings with random idle bursts on
// both channels. Checking is done by dnapk_result_checker; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module dna_read_prefix_key_and_pack_test;
  import dnapk_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 5;
  localparam int DRAIN_CYCLES     = 4;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int HOLD_BASES       = 30;
  localparam int IDLE_LIMIT       = 2000;
  localparam int RANDOM_BASES     = 580;
  localparam int CALM_BASES       = 90;

  localparam logic [LETTER_W-1:0] LETTER_Z      = 5'd25;
  localparam logic [LETTER_W-1:0] LETTER_PAST_Z = 5'd26;
  localparam logic [LETTER_W-1:0] LETTER_TOP    = 5'd31;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_PREFIX_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [LETTER_W-1:0]   letter_i    = LETTER_A;
  logic                  last_base_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  kind_o;
  logic [VALUE_W-1:0]    value_o;
  logic                  last_of_read_o;

  int fail_count;
  int pending;
  int results_seen;

  // idle control shared by the two sides
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  bit          calm         = 1'b0;

  // settings currently loaded, used to tell ignored bases apart
  logic [PLEN_W-1:0] cur_plen  = PLEN_W'(PLEN_RESET);
  logic              cur_limit = 1'b0;
  logic [CLEN_W-1:0] cur_clen  = '0;

  int unsigned bases_sent    = 0;
  int unsigned reads_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned random_bases  = 0;
  int unsigned idle_cycles   = 0;

  dna_read_prefix_key_and_pack u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .letter_i       (letter_i),
    .last_base_i    (last_base_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .last_of_read_o (last_of_read_o)
  );

  dnapk_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .letter_i       (letter_i),
    .last_base_i    (last_base_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .value_i        (value_o),
    .last_of_read_i (last_of_read_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left == 0 && rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop sending and wait until every predicted result has gone out.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [PLEN_W-1:0] plen, input logic lim,
                                input logic [CLEN_W-1:0] clen);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PREFIX_LENGTH;
    cfg_data_i <= CFG_DATA_W'(plen);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COMPARE_LIMIT_ON;
    cfg_data_i <= CFG_DATA_W'(lim);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COMPARE_LENGTH;
    cfg_data_i <= clen;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_plen  = plen;
    cur_limit = lim;
    cur_clen  = clen;
    settings_used++;
  endtask

  task automatic send_base(input logic [LETTER_W-1:0] letter, input bit last);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    letter_i    <= letter;
    last_base_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bases_sent++;
    if (last) reads_sent++;
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return LETTER_A;
    if (r < 40) return LETTER_C;
    if (r < 60) return LETTER_G;
    if (r < 78) return LETTER_T;
    if (r < 97) return LETTER_W'($urandom_range(LETTER_A, LETTER_Z));
    return LETTER_W'($urandom_range(LETTER_PAST_Z, LETTER_TOP));
  endfunction

  function automatic int unsigned pick_read_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 20);
    if (r < 90) return $urandom_range(21, 60);
    return $urandom_range(61, 160);
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 4))
      0, 1:    return 0;
      2:       return 10;
      3:       return 25;
      default: return 50;
    endcase
  endfunction

  task automatic send_random_read(input int unsigned len);
    int unsigned eff_plen;
    eff_plen = (cur_plen > MAX_KEY_BASES) ? MAX_KEY_BASES : cur_plen;
    for (int unsigned i = 0; i < len; i++) begin
      send_base(pick_letter(), i == len - 1);
      // bases past both the compare limit and the prefix are dropped by the block
      if (!(cur_limit && i >= cur_clen && i >= eff_plen)) random_bases++;
    end
  endtask

  task automatic random_phase(input int unsigned n_reads);
    logic [PLEN_W-1:0] plen;
    logic              lim;
    logic [CLEN_W-1:0] clen;
    case ($urandom_range(0, 5))
      0:       plen = '0;
      1:       plen = PLEN_W'(1);
      2:       plen = PLEN_W'(MAX_KEY_BASES);
      3:       plen = PLEN_W'($urandom_range(MAX_KEY_BASES + 1, (1 << PLEN_W) - 1));
      default: plen = PLEN_W'($urandom_range(0, 16));
    endcase
    lim = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0:       clen = '0;
      1:       clen = CLEN_W'(plen + $urandom_range(0, 3));
      2:       clen = '1;
      3:       clen = CLEN_W'($urandom);
      default: clen = CLEN_W'($urandom_range(1, 60));
    endcase
    apply_settings(plen, lim, clen);
    tx_gap_pct   = calm ? 0 : pick_idle_pct();
    rx_stall_pct = calm ? 0 : pick_idle_pct();
    repeat (n_reads) send_random_read(pick_read_len());
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed reads, some idling on both sides.
    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    // read shorter than the reset prefix
    send_base(LETTER_A, 1'b0);
    send_base(LETTER_C, 1'b0);
    send_base(LETTER_G, 1'b1);
    // empty prefix with a zero compare length: key only, rest dropped
    apply_settings('0, 1'b1, '0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_A, 1'b1);
    // compare limit stops packing partway, later bases give nothing
    apply_settings(PLEN_W'(2), 1'b1, CLEN_W'(5));
    send_base(LETTER_G, 1'b0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_A, 1'b0);
    send_base(LETTER_C, 1'b0);
    send_base(LETTER_G, 1'b0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_TOP, 1'b1);
    // compare limit falls inside the prefix
    apply_settings(PLEN_W'(3), 1'b1, CLEN_W'(2));
    send_base(LETTER_A, 1'b0);
    send_base(LETTER_C, 1'b0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_G, 1'b1);
    // empty prefix: zero key and a word from the same base
    apply_settings('0, 1'b0, '0);
    send_base(LETTER_PAST_Z, 1'b1);
    send_base(LETTER_A, 1'b0);
    send_base(LETTER_C, 1'b0);
    send_base(LETTER_G, 1'b0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_Z, 1'b1);
    // prefix length beyond the key limit
    apply_settings('1, 1'b0, '0);
    send_base(LETTER_T, 1'b0);
    send_base(LETTER_TOP, 1'b1);

    // Long output hold-off; one-base reads give two results each.
    apply_settings('0, 1'b0, '0);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    repeat (HOLD_BASES) send_base(pick_letter(), 1'($urandom_range(0, 1)));
    send_base(pick_letter(), 1'b1);

    while (random_bases < RANDOM_BASES - CALM_BASES) random_phase($urandom_range(2, 5));
    calm = 1'b1;
    while (random_bases < RANDOM_BASES) random_phase(1);

    settle();
    $display("Sent %0d bases in %0d reads under %0d register settings, %0d results checked.",
             bases_sent, reads_sent, settings_used, results_seen);
    $display("Covered empty and oversized prefixes, compare limits and a %0d-cycle hold-off.",
             LONG_HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
